>>> sv/tlbsc_pkg.sv
// Shared constants, types and state encoding for the second-chance TLB block.
package tlbsc_pkg;

   localparam int OFFSET_BITS_DEFAULT  = 8;
   localparam int FRAME_COUNT_DEFAULT  = 128;
   localparam int TLB_ENTRIES_DEFAULT  = 16;
   localparam int ADDRESS_BITS_DEFAULT = 16;

   localparam int FRAME_W    = 7;
   localparam int PHYS_W     = 15;
   localparam int FETCH_W    = 8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TLB,
      ST_TABLE,
      ST_ALLOC,
      ST_FILL,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic load;
      logic tlb_look;
      logic table_look;
      logic alloc;
      logic fill;
      logic send;
   } cmd_type;

   typedef struct packed {
      logic tlb_hit;
      logic table_hit;
      logic rsp_taken;
   } status_type;

endpackage

>>> sv/tlbsc_ctrl.sv
// Controller state machine sequencing lookup, allocation and TLB refill.
module tlbsc_ctrl
   import tlbsc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_TLB;
         end
         ST_TLB: begin
            state_in = ST_TABLE;
         end
         ST_TABLE: begin
            if (status.tlb_hit) state_in = ST_RESP;
            else if (status.table_hit) state_in = ST_FILL;
            else state_in = ST_ALLOC;
         end
         ST_ALLOC: begin
            state_in = ST_FILL;
         end
         ST_FILL: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (status.rsp_taken) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_TLB:   cmd.tlb_look   = 1'b1;
         ST_TABLE: cmd.table_look = 1'b1;
         ST_ALLOC: cmd.alloc      = 1'b1;
         ST_FILL:  cmd.fill       = 1'b1;
         ST_RESP:  cmd.send       = 1'b1;
         default:  cmd = '0;
      endcase
   end

endmodule

>>> sv/tlbsc_dp.sv
// Datapath holding the TLB, the frame table, the hands and the result.
module tlbsc_dp
   import tlbsc_pkg::*;
#(
   parameter int OFFSET_BITS  = OFFSET_BITS_DEFAULT,
   parameter int FRAME_COUNT  = FRAME_COUNT_DEFAULT,
   parameter int TLB_ENTRIES  = TLB_ENTRIES_DEFAULT,
   parameter int ADDRESS_BITS = ADDRESS_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output status_type              status,
   input  logic [ADDRESS_BITS-1:0] req_logical_address,
   input  logic                    rsp_ready,
   output logic [FRAME_W-1:0]      rsp_frame_index,
   output logic [PHYS_W-1:0]       rsp_physical_address,
   output logic                    rsp_tlb_hit,
   output logic                    rsp_page_fault,
   output logic [FETCH_W-1:0]      rsp_fetch_page
);

   localparam int PAGE_W = ADDRESS_BITS - OFFSET_BITS;
   localparam int FI_W   = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
   localparam int TI_W   = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

   logic [PAGE_W-1:0]      page_ff;
   logic [OFFSET_BITS-1:0] offset_ff;
   logic [PAGE_W-1:0]      tlb_page_ff  [TLB_ENTRIES];
   logic [FI_W-1:0]        tlb_frame_ff [TLB_ENTRIES];
   logic [TLB_ENTRIES-1:0] tlb_valid_ff, tlb_ref_ff;
   logic [PAGE_W-1:0]      table_page_ff [FRAME_COUNT];
   logic [FRAME_COUNT-1:0] table_valid_ff, table_ref_ff;
   logic [FI_W:0]          table_hand_ff;
   logic [TI_W:0]          tlb_hand_ff;
   logic [FI_W-1:0]        frame_ff;
   logic                   hit_ff, fault_ff;
   logic [TI_W-1:0]        hit_slot_ff;

   logic                   tlb_match;
   logic [TI_W-1:0]        tlb_match_idx;
   logic                   tbl_match;
   logic [FI_W-1:0]        tbl_match_idx;

   always_comb begin
      tlb_match = 1'b0;
      tlb_match_idx = '0;
      for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
         if (tlb_valid_ff[i] && tlb_page_ff[i] == page_ff) begin
            tlb_match = 1'b1;
            tlb_match_idx = TI_W'(i);
         end
      end
   end

   always_comb begin
      tbl_match = 1'b0;
      tbl_match_idx = '0;
      for (int i = FRAME_COUNT - 1; i >= 0; i--) begin
         if (table_valid_ff[i] && table_page_ff[i] == page_ff) begin
            tbl_match = 1'b1;
            tbl_match_idx = FI_W'(i);
         end
      end
   end

   // Second-chance choice for the frame table.
   logic [FI_W-1:0] tbl_pick;
   logic            tbl_all_valid;
   always_comb begin
      logic got_inv, got_hand, got_zero;
      logic [FI_W-1:0] inv_i, hand_i, zero_i;
      got_inv = 1'b0; got_hand = 1'b0; got_zero = 1'b0;
      inv_i = '0; hand_i = '0; zero_i = '0;
      for (int i = FRAME_COUNT - 1; i >= 0; i--) begin
         if (!table_valid_ff[i]) begin
            got_inv = 1'b1; inv_i = FI_W'(i);
         end
         if (!table_ref_ff[i]) begin
            got_zero = 1'b1; zero_i = FI_W'(i);
            if ((FI_W+1)'(i) >= table_hand_ff) begin
               got_hand = 1'b1; hand_i = FI_W'(i);
            end
         end
      end
      tbl_all_valid = !got_inv;
      if (got_inv) tbl_pick = inv_i;
      else if (got_hand) tbl_pick = hand_i;
      else if (got_zero) tbl_pick = zero_i;
      else tbl_pick = '0;
   end

   // Second-chance choice for the TLB, taken after any eviction is applied.
   logic [TI_W-1:0] tlb_pick;
   logic            tlb_all_valid;
   always_comb begin
      logic got_inv, got_hand, got_zero;
      logic [TI_W-1:0] inv_i, hand_i, zero_i;
      got_inv = 1'b0; got_hand = 1'b0; got_zero = 1'b0;
      inv_i = '0; hand_i = '0; zero_i = '0;
      for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
         if (!tlb_valid_ff[i]) begin
            got_inv = 1'b1; inv_i = TI_W'(i);
         end
         if (!tlb_ref_ff[i]) begin
            got_zero = 1'b1; zero_i = TI_W'(i);
            if ((TI_W+1)'(i) >= tlb_hand_ff) begin
               got_hand = 1'b1; hand_i = TI_W'(i);
            end
         end
      end
      tlb_all_valid = !got_inv;
      if (got_inv) tlb_pick = inv_i;
      else if (got_hand) tlb_pick = hand_i;
      else if (got_zero) tlb_pick = zero_i;
      else tlb_pick = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tlb_valid_ff   <= '0;
         tlb_ref_ff     <= '0;
         table_valid_ff <= '0;
         table_ref_ff   <= '0;
         table_hand_ff  <= '0;
         tlb_hand_ff    <= '0;
      end else begin
         if (cmd.table_look) begin
            if (hit_ff) begin
               tlb_ref_ff[hit_slot_ff] <= 1'b1;
            end else if (tbl_match) begin
               table_ref_ff[tbl_match_idx] <= 1'b1;
            end
         end
         if (cmd.alloc) begin
            if (tbl_all_valid) table_ref_ff <= '0;
            table_hand_ff <= {1'b0, tbl_pick} + 1'b1;
            table_valid_ff[tbl_pick] <= 1'b1;
            for (int i = 0; i < TLB_ENTRIES; i++) begin
               if (tlb_valid_ff[i] && tlb_frame_ff[i] == tbl_pick) begin
                  tlb_valid_ff[i] <= 1'b0;
                  tlb_ref_ff[i]   <= 1'b0;
               end
            end
         end
         if (cmd.fill) begin
            if (tlb_all_valid) tlb_ref_ff <= '0;
            tlb_hand_ff <= {1'b0, tlb_pick} + 1'b1;
            tlb_valid_ff[tlb_pick] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         page_ff   <= req_logical_address[ADDRESS_BITS-1:OFFSET_BITS];
         offset_ff <= req_logical_address[OFFSET_BITS-1:0];
         fault_ff  <= 1'b0;
      end
      if (cmd.tlb_look) begin
         hit_ff      <= tlb_match;
         hit_slot_ff <= tlb_match_idx;
         frame_ff    <= tlb_frame_ff[tlb_match_idx];
      end
      if (cmd.table_look) begin
         if (!hit_ff) frame_ff <= tbl_match_idx;
      end
      if (cmd.alloc) begin
         fault_ff <= 1'b1;
         frame_ff <= tbl_pick;
         table_page_ff[tbl_pick] <= page_ff;
      end
      if (cmd.fill) begin
         tlb_page_ff[tlb_pick]  <= page_ff;
         tlb_frame_ff[tlb_pick] <= frame_ff;
      end
   end

   assign status.tlb_hit   = hit_ff;
   assign status.table_hit = tbl_match;
   assign status.rsp_taken = cmd.send & rsp_ready;

   logic [FI_W+OFFSET_BITS-1:0] phys;
   assign phys = {frame_ff, offset_ff};

   assign rsp_frame_index      = FRAME_W'(frame_ff);
   assign rsp_physical_address = PHYS_W'(phys);
   assign rsp_tlb_hit          = hit_ff;
   assign rsp_page_fault       = fault_ff;
   assign rsp_fetch_page       = fault_ff ? FETCH_W'(page_ff) : '0;

   a_fill_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.fill |=> tlb_valid_ff[$past(tlb_pick)])
      else $error("TLB fill did not mark the slot valid");
   a_alloc_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.alloc |=> table_valid_ff[$past(tbl_pick)] && fault_ff)
      else $error("allocation did not mark the frame valid");
   a_hit_no_fault: assert property (@(posedge clock) disable iff (reset)
      cmd.send |-> !(hit_ff && fault_ff))
      else $error("hit and fault together");

endmodule

>>> sv/tlb_page_table_second_chance_top.sv
// Top level of the TLB with frame table and second-chance replacement.
// A request passes the TLB and table lookup states; a TLB hit then goes to the response,
// a table hit through fill and a page fault through allocate and fill. One request is
// handled at a time by the controller; it accepts the next only once the response is taken.
// Reset clears all valid bits, reference bits and both hands.
module tlb_page_table_second_chance_top
   import tlbsc_pkg::*;
#(
   parameter int OFFSET_BITS  = OFFSET_BITS_DEFAULT,
   parameter int FRAME_COUNT  = FRAME_COUNT_DEFAULT,
   parameter int TLB_ENTRIES  = TLB_ENTRIES_DEFAULT,
   parameter int ADDRESS_BITS = ADDRESS_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [ADDRESS_BITS-1:0] req_logical_address,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [FRAME_W-1:0]      rsp_frame_index,
   output logic [PHYS_W-1:0]       rsp_physical_address,
   output logic                    rsp_tlb_hit,
   output logic                    rsp_page_fault,
   output logic [FETCH_W-1:0]      rsp_fetch_page
);

   cmd_type    cmd;
   status_type status;

   tlbsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tlbsc_dp #(
      .OFFSET_BITS  (OFFSET_BITS),
      .FRAME_COUNT  (FRAME_COUNT),
      .TLB_ENTRIES  (TLB_ENTRIES),
      .ADDRESS_BITS (ADDRESS_BITS)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_logical_address  (req_logical_address),
      .rsp_ready            (rsp_ready),
      .rsp_frame_index      (rsp_frame_index),
      .rsp_physical_address (rsp_physical_address),
      .rsp_tlb_hit          (rsp_tlb_hit),
      .rsp_page_fault       (rsp_page_fault),
      .rsp_fetch_page       (rsp_fetch_page)
   );

   assign rsp_valid = cmd.send;

endmodule
